// ----- rtl/cesc_pkg.sv -----
// Shared types, character constants and lookup functions for the escape codec.
package cesc_pkg;

  localparam logic [7:0] ChBackslash = 8'd92;
  localparam logic [7:0] ChQuote     = 8'd34;
  localparam logic [7:0] ChZero      = 8'd48;
  localparam logic [7:0] ChNine      = 8'd57;
  localparam logic [7:0] ChLowX      = 8'd120;
  localparam logic [7:0] ChLowA      = 8'd97;
  localparam logic [7:0] ChLowB      = 8'd98;
  localparam logic [7:0] ChLowF      = 8'd102;
  localparam logic [7:0] ChLowN      = 8'd110;
  localparam logic [7:0] ChLowR      = 8'd114;
  localparam logic [7:0] ChLowT      = 8'd116;
  localparam logic [7:0] ChLowV      = 8'd118;
  localparam logic [7:0] ChUpA       = 8'd65;
  localparam logic [7:0] ChUpF       = 8'd70;
  localparam logic [7:0] CtlBel      = 8'd7;
  localparam logic [7:0] CtlBs       = 8'd8;
  localparam logic [7:0] CtlTab      = 8'd9;
  localparam logic [7:0] CtlLf       = 8'd10;
  localparam logic [7:0] CtlVt       = 8'd11;
  localparam logic [7:0] CtlFf       = 8'd12;
  localparam logic [7:0] CtlCr       = 8'd13;
  localparam logic [7:0] FirstPrint  = 8'd32;
  localparam logic [7:0] LastPrint   = 8'd126;
  localparam logic [7:0] LowHexBase  = 8'd87;  // 'a' - 10
  localparam logic [7:0] UpHexBase   = 8'd55;  // 'A' - 10

  localparam int unsigned MaxBytes = 4;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,  // nothing held
    PH_BSL   = 2'd1,  // backslash held
    PH_SEL   = 2'd2,  // backslash and selector held
    PH_DIGIT = 2'd3   // backslash, selector and first digit held
  } cesc_phase_e;

  // Up to four result bytes, byte 0 goes out first.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] data;
    logic [2:0]               cnt;
  } cesc_res_t;

  function automatic logic [7:0] letter_of(input logic [7:0] c);
    logic [7:0] l;
    case (c)
      ChBackslash: l = ChBackslash;
      CtlCr:       l = ChLowR;
      CtlLf:       l = ChLowN;
      CtlTab:      l = ChLowT;
      CtlBel:      l = ChLowA;
      CtlBs:       l = ChLowB;
      CtlVt:       l = ChLowV;
      CtlFf:       l = ChLowF;
      ChQuote:     l = ChQuote;
      default:     l = 8'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] control_of(input logic [7:0] c);
    logic [7:0] v;
    case (c)
      ChBackslash: v = ChBackslash;
      ChLowR:      v = CtlCr;
      ChLowN:      v = CtlLf;
      ChLowT:      v = CtlTab;
      ChLowA:      v = CtlBel;
      ChLowB:      v = CtlBs;
      ChLowV:      v = CtlVt;
      ChLowF:      v = CtlFf;
      ChQuote:     v = ChQuote;
      default:     v = 8'd0;
    endcase
    return v;
  endfunction

  // Digit value for 0-9, a-f, A-F; any other byte keeps its raw value.
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= ChZero && c <= ChNine) begin
      v = c - ChZero;
    end else if (c >= ChLowA && c <= ChLowF) begin
      v = c - LowHexBase;
    end else if (c >= ChUpA && c <= ChUpF) begin
      v = c - UpHexBase;
    end else begin
      v = c;
    end
    return v;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] ch;
    if (n < 4'd10) begin
      ch = ChZero + {4'd0, n};
    end else begin
      ch = UpHexBase + {4'd0, n};
    end
    return ch;
  endfunction

endpackage

// ----- rtl/c_escape_codec_core.sv -----
// Top level of the C escape codec: mode register, both codec paths and the output register.
//
// Usage:
//   Input items arrive on the s_axis group: tdata carries one text byte and tlast marks
//   the last byte of a region. Result items leave on the m_axis group: tdata carries a
//   produced byte, tuser is high on the last byte caused by one input item, and tlast is
//   high on the final byte of a region.
//   cfg_we_i/cfg_wdata_i write the mode (0 escape, 1 unescape); a write also drops any
//   partly received escape sequence. Write only while the block is idle.
// Timing and throughput:
//   The first byte of an item's result appears in the cycle after the item is accepted.
//   An item producing n bytes (0 to 4) holds the output register until its bytes are
//   taken; the next item is taken in the cycle the last of those bytes is taken, so
//   single-byte results run at one item per cycle while m_axis_tready_i stays high.
//   Items that produce no byte (held backslash or digits) leave the register empty.
// Reset:
//   rst_ni clears the mode to escape, the pending sequence and the output register.
// Stall:
//   While m_axis_tready_i is low a waiting byte holds and s_axis_tready_o stays low;
//   with the output register empty the next item is still taken.
module c_escape_codec_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,      // unescape_mode
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // stream_end
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tuser_o,   // [0] item_done
  output logic       m_axis_tlast_o    // out_stream_end
);

  logic                mode_q;
  logic                accept;
  logic                free;
  cesc_pkg::cesc_res_t enc_res;
  cesc_pkg::cesc_res_t dec_res;
  cesc_pkg::cesc_res_t res;

  assign s_axis_tready_o = free;
  assign accept          = s_axis_tvalid_i && free;
  assign res             = mode_q ? dec_res : enc_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  cesc_encode u_encode (
    .byte_i (s_axis_tdata_i),
    .res_o  (enc_res)
  );

  cesc_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (accept && mode_q),
    .clear_i (cfg_we_i),
    .byte_i  (s_axis_tdata_i),
    .end_i   (s_axis_tlast_i),
    .res_o   (dec_res)
  );

  cesc_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .res_i        (res),
    .end_i        (s_axis_tlast_i),
    .free_o       (free),
    .tvalid_o     (m_axis_tvalid_o),
    .tready_i     (m_axis_tready_i),
    .byte_o       (m_axis_tdata_o),
    .item_done_o  (m_axis_tuser_o),
    .stream_end_o (m_axis_tlast_o)
  );

endmodule

// ----- rtl/cesc_encode.sv -----
// Escape path: expands one raw byte into one to four output bytes.
module cesc_encode (
  input  logic [7:0]         byte_i,
  output cesc_pkg::cesc_res_t res_o
);

  logic [7:0] letter;

  assign letter = cesc_pkg::letter_of(byte_i);

  always_comb begin
    res_o.data = '0;
    res_o.cnt  = 3'd1;
    if (letter != 8'd0) begin
      res_o.data[0] = cesc_pkg::ChBackslash;
      res_o.data[1] = letter;
      res_o.cnt     = 3'd2;
    end else if (byte_i < cesc_pkg::FirstPrint) begin
      res_o.data[0] = cesc_pkg::ChBackslash;
      res_o.data[1] = cesc_pkg::ChZero;
      res_o.data[2] = cesc_pkg::ChZero + {6'd0, byte_i[4:3]};
      res_o.data[3] = cesc_pkg::ChZero + {5'd0, byte_i[2:0]};
      res_o.cnt     = 3'd4;
    end else if (byte_i > cesc_pkg::LastPrint) begin
      res_o.data[0] = cesc_pkg::ChBackslash;
      res_o.data[1] = cesc_pkg::ChLowX;
      res_o.data[2] = cesc_pkg::hex_char(byte_i[7:4]);
      res_o.data[3] = cesc_pkg::hex_char(byte_i[3:0]);
      res_o.cnt     = 3'd4;
    end else begin
      res_o.data[0] = byte_i;
    end
  end

endmodule

// ----- rtl/cesc_decode.sv -----
// Unescape path: pending-sequence state machine and decoded result bytes.
module cesc_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                clear_i,
  input  logic [7:0]          byte_i,
  input  logic                end_i,
  output cesc_pkg::cesc_res_t res_o
);

  cesc_pkg::cesc_phase_e phase_q, phase_d;
  logic                  is_hex_q, is_hex_d;
  logic [7:0]            first_q, first_d;

  logic [7:0] ctl;
  logic       is_sel;
  logic [7:0] sel_char;
  logic [7:0] oct_hi;
  logic [7:0] hex_hi;
  logic [7:0] value;

  assign ctl      = cesc_pkg::control_of(byte_i);
  assign is_sel   = (byte_i == cesc_pkg::ChZero) || (byte_i == cesc_pkg::ChLowX);
  assign sel_char = is_hex_q ? cesc_pkg::ChLowX : cesc_pkg::ChZero;
  assign oct_hi   = first_q - cesc_pkg::ChZero;
  assign hex_hi   = cesc_pkg::hex_value(first_q);
  assign value    = is_hex_q ? ({hex_hi[3:0], 4'd0} + cesc_pkg::hex_value(byte_i))
                             : ({oct_hi[4:0], 3'd0} + (byte_i - cesc_pkg::ChZero));

  // Next state
  always_comb begin
    phase_d  = phase_q;
    is_hex_d = is_hex_q;
    first_d  = first_q;
    if (step_i) begin
      case (phase_q)
        cesc_pkg::PH_IDLE: begin
          if (byte_i == cesc_pkg::ChBackslash) phase_d = cesc_pkg::PH_BSL;
        end
        cesc_pkg::PH_BSL: begin
          if (ctl == 8'd0 && is_sel) begin
            phase_d  = cesc_pkg::PH_SEL;
            is_hex_d = (byte_i == cesc_pkg::ChLowX);
          end else begin
            phase_d = cesc_pkg::PH_IDLE;
          end
        end
        cesc_pkg::PH_SEL: begin
          first_d = byte_i;
          phase_d = cesc_pkg::PH_DIGIT;
        end
        default: phase_d = cesc_pkg::PH_IDLE;
      endcase
      // end of region drops whatever is still held
      if (end_i) begin
        phase_d  = cesc_pkg::PH_IDLE;
        is_hex_d = 1'b0;
        first_d  = 8'd0;
      end
    end
    if (clear_i) begin
      phase_d  = cesc_pkg::PH_IDLE;
      is_hex_d = 1'b0;
      first_d  = 8'd0;
    end
  end

  // Result bytes
  always_comb begin
    res_o.data = '0;
    res_o.cnt  = 3'd0;
    case (phase_q)
      cesc_pkg::PH_IDLE: begin
        if (byte_i != cesc_pkg::ChBackslash) begin
          res_o.data[0] = byte_i;
          res_o.cnt     = 3'd1;
        end else if (end_i) begin
          res_o.data[0] = cesc_pkg::ChBackslash;
          res_o.cnt     = 3'd1;
        end
      end
      cesc_pkg::PH_BSL: begin
        if (ctl != 8'd0) begin
          res_o.data[0] = ctl;
          res_o.cnt     = 3'd1;
        end else if (is_sel) begin
          if (end_i) begin
            res_o.data[0] = cesc_pkg::ChBackslash;
            res_o.data[1] = byte_i;
            res_o.cnt     = 3'd2;
          end
        end else begin
          res_o.data[0] = cesc_pkg::ChBackslash;
          res_o.data[1] = byte_i;
          res_o.cnt     = 3'd2;
        end
      end
      cesc_pkg::PH_SEL: begin
        if (end_i) begin
          res_o.data[0] = cesc_pkg::ChBackslash;
          res_o.data[1] = sel_char;
          res_o.data[2] = byte_i;
          res_o.cnt     = 3'd3;
        end
      end
      default: begin
        res_o.data[0] = value;
        res_o.cnt     = 3'd1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= cesc_pkg::PH_IDLE;
      is_hex_q <= 1'b0;
      first_q  <= 8'd0;
    end else begin
      phase_q  <= phase_d;
      is_hex_q <= is_hex_d;
      first_q  <= first_d;
    end
  end

endmodule

// ----- rtl/cesc_serializer.sv -----
// Result register: holds up to four bytes of one item and sends them one per cycle while tready_i is high.
module cesc_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  cesc_pkg::cesc_res_t res_i,
  input  logic                end_i,
  output logic                free_o,
  output logic                tvalid_o,
  input  logic                tready_i,
  output logic [7:0]          byte_o,
  output logic                item_done_o,
  output logic                stream_end_o
);

  logic [cesc_pkg::MaxBytes-1:0][7:0] data_q, data_d;
  logic [2:0]                         cnt_q, cnt_d;
  logic                               end_q, end_d;
  logic                               pop;

  assign tvalid_o     = (cnt_q != 3'd0);
  assign pop          = tvalid_o && tready_i;
  assign free_o       = (cnt_q == 3'd0) || (cnt_q == 3'd1 && tready_i);
  assign byte_o       = data_q[0];
  assign item_done_o  = (cnt_q == 3'd1);
  assign stream_end_o = (cnt_q == 3'd1) && end_q;

  always_comb begin
    data_d = data_q;
    cnt_d  = cnt_q;
    end_d  = end_q;
    if (load_i) begin
      data_d = res_i.data;
      cnt_d  = res_i.cnt;
      end_d  = end_i;
    end else if (pop) begin
      // advance to the next byte of the item
      data_d = {8'd0, data_q[cesc_pkg::MaxBytes-1:1]};
      cnt_d  = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      end_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      end_q <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule
